### rtl/fsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fsqrt_pkg
// Shared types and constants of the single-precision square root pipeline.
// ----------------------------------------------------------------------------
package fsqrt_pkg;

    localparam logic [31:0] NEG_INVALID = 32'h7F80_0001;
    localparam int          ROOT_BITS   = 24;
    localparam int          BITS_PER_ST = 4;
    localparam int          ROOT_STAGES = ROOT_BITS / BITS_PER_ST;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_ZERO    = 2'd1,
        RM_DOWN    = 2'd2,
        RM_UP      = 2'd3
    } t_round;

    // Partial root state travelling down the pipeline.
    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic [7:0]  obexp;
        logic [1:0]  mode;
        logic [23:0] y;
        logic [26:0] r;
        logic [25:0] m;
    } t_work;

endpackage

### rtl/fsqrt_prep.sv
// ----------------------------------------------------------------------------
// fsqrt_prep
// Classifies the operand, normalizes subnormals and evens the exponent.
// ----------------------------------------------------------------------------
module fsqrt_prep
    import fsqrt_pkg::*;
(
    input  logic [31:0] i_x,
    input  logic [1:0]  i_mode,
    output t_work       o_work
);

    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [4:0]  lz;
    logic [23:0] mant;
    logic [9:0]  e;
    logic [24:0] m2;

    always_comb begin
        bexp = i_x[30:23];
        frac = i_x[22:0];
        lz   = 5'd0;
        for (int k = 22; k >= 0; k--) begin
            if (frac[k] && lz == 5'd0 && (frac >> (k + 1)) == 23'd0) begin
                lz = 5'(23 - k);
            end
        end
        if (bexp == 8'd0) begin
            mant = {1'b0, frac} << lz;
            e    = 10'(-126) - 10'(lz);
        end else begin
            mant = {1'b1, frac};
            e    = {2'b00, bexp} - 10'd127;
        end
        if (e[0]) begin
            m2 = {mant, 1'b0};
            e  = e - 10'd1;
        end else begin
            m2 = {1'b0, mant};
        end
        o_work          = '0;
        o_work.mode     = i_mode;
        o_work.special  = 1'b0;
        o_work.spec_val = i_x;
        if (i_x > 32'h8000_0000) begin
            o_work.special  = 1'b1;
            o_work.spec_val = NEG_INVALID;
        end else if (bexp == 8'hFF || i_x[30:0] == 31'd0) begin
            o_work.special = 1'b1;
        end
        o_work.obexp = 8'(10'd127 + {e[9], e[9:1]});
        o_work.y     = 24'h80_0000;
        o_work.r     = 27'(m2) - 27'h80_0000;
        o_work.m     = 26'(m2);
    end

endmodule

### rtl/fsqrt_root_stage.sv
// ----------------------------------------------------------------------------
// fsqrt_root_stage
// Registered stage of the restoring root; resolves up to BITS_PER_ST root bits.
// ----------------------------------------------------------------------------
module fsqrt_root_stage
    import fsqrt_pkg::*;
#(
    parameter int FIRST_BIT = 22
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_valid,
    output t_work o_work
);

    t_work       r_work;
    t_work       n_work;
    logic        r_valid;
    logic [26:0] t;

    always_comb begin
        n_work = i_work;
        for (int k = 0; k < BITS_PER_ST; k++) begin
            if (FIRST_BIT - k >= 0) begin
                n_work.r = n_work.r << 1;
                t = 27'({n_work.y, 1'b0}) + (27'd1 << (FIRST_BIT - k));
                if (n_work.r >= t) begin
                    n_work.r = n_work.r - t;
                    n_work.y = n_work.y | (24'd1 << (FIRST_BIT - k));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

### rtl/fsqrt_round.sv
// ----------------------------------------------------------------------------
// fsqrt_round
// Forms round and sticky bits, rounds and packs the result or passes a special.
// ----------------------------------------------------------------------------
module fsqrt_round
    import fsqrt_pkg::*;
(
    input  t_work       i_work,
    output logic [31:0] o_root
);

    logic [28:0] r4;
    logic [25:0] y4;
    logic [28:0] t;
    logic [24:0] res;
    logic        up;

    always_comb begin
        r4 = {i_work.r, 2'b00};
        y4 = {i_work.y, 2'b00};
        t  = 29'(y4) + 29'd1;
        if (r4 >= t) begin
            r4    = r4 - t;
            y4[1] = 1'b1;
        end
        if (r4 != 29'd0) begin
            y4[0] = 1'b1;
        end
        res = {1'b0, y4[25:2]};
        case (t_round'(i_work.mode))
            RM_NEAREST: up = (y4[1:0] == 2'b10) ? res[0] : y4[1];
            RM_UP:      up = (y4[1:0] != 2'b00);
            default:    up = 1'b0;
        endcase
        res = res + 25'(up);
        if (i_work.special) begin
            o_root = i_work.spec_val;
        end else begin
            o_root = ({1'b0, i_work.obexp, 23'd0}) + 32'(res - 25'h80_0000);
        end
    end

endmodule

### rtl/fp32_square_root.sv
// ----------------------------------------------------------------------------
// fp32_square_root
// Pipelined, correctly rounded IEEE-754 single-precision square root.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the output is not stalled. The pipeline
// is an input register, six root stages resolving four root bits each (three
// in the last), and an output register after rounding. A stalled output holds
// the whole pipeline in place.
module fp32_square_root
    import fsqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_operand,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_root
);

    logic [1:0]  r_mode;
    logic        r_in_valid;
    logic [31:0] r_in_x;
    logic [1:0]  r_in_mode;
    logic        r_out_valid;
    logic [31:0] r_out_root;
    logic        en;
    t_work       prep_work;
    t_work       st_work  [ROOT_STAGES+1];
    logic        st_valid [ROOT_STAGES+1];
    logic [31:0] rounded;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 2'd0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (en) begin
                r_in_valid  <= i_valid;
                r_out_valid <= st_valid[ROOT_STAGES];
            end
        end
        if (en) begin
            r_in_x     <= i_operand;
            r_in_mode  <= r_mode;
            r_out_root <= rounded;
        end
    end

    fsqrt_prep u_prep (
        .i_x    (r_in_x),
        .i_mode (r_in_mode),
        .o_work (prep_work)
    );

    assign st_work[0]  = prep_work;
    assign st_valid[0] = r_in_valid;

    for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
        fsqrt_root_stage #(
            .FIRST_BIT (22 - s * BITS_PER_ST)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (st_valid[s]),
            .i_work  (st_work[s]),
            .o_valid (st_valid[s+1]),
            .o_work  (st_work[s+1])
        );
    end

    fsqrt_round u_round (
        .i_work (st_work[ROOT_STAGES]),
        .o_root (rounded)
    );

    assign o_valid = r_out_valid;
    assign o_root  = r_out_root;

endmodule
